// ===== rtl/irpw_pkg.sv =====
// Shared types and constants for the infrared pulse-width frame decoder.
// Holds the phase codes, the register indexes and the settings and result structs.
// No dependencies.
package irpw_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned REG_W    = 16;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned CFG_IDX_W = 3;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 40;

	// Decoder phases.
	localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SOF  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SOW  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MARK = 3'd3;
	localparam logic [PHASE_W-1:0] PH_BIT  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_REP  = 3'd5;

	// Register indexes on the settings port.
	localparam logic [CFG_IDX_W-1:0] REG_SOF_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOF_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOW_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOW_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_MAX = 3'd7;

	// Register reset values in timer ticks.
	localparam logic [REG_W-1:0] RST_SOF_MIN   = 16'd1000;
	localparam logic [REG_W-1:0] RST_SOF_MAX   = 16'd1250;
	localparam logic [REG_W-1:0] RST_SOW_MIN   = 16'd375;
	localparam logic [REG_W-1:0] RST_SOW_MAX   = 16'd625;
	localparam logic [REG_W-1:0] RST_MARK_MIN  = 16'd70;
	localparam logic [REG_W-1:0] RST_MARK_MAX  = 16'd95;
	localparam logic [REG_W-1:0] RST_ONE_MIN   = 16'd125;
	localparam logic [REG_W-1:0] RST_SPACE_MAX = 16'd312;

	// Widths this close to the wrap are taken as slightly past it.
	localparam logic [TIME_W-1:0] WRAP_LIMIT = 32'hFFFF_FF00;
	localparam logic [TIME_W-1:0] WRAP_FIX   = 32'h0000_0100;

	// The 33rd good timing mark closes the frame.
	localparam logic [COUNT_W-1:0] LAST_MARK = 6'd33;

	typedef struct packed {
		logic [REG_W-1:0] sof_min;
		logic [REG_W-1:0] sof_max;
		logic [REG_W-1:0] sow_min;
		logic [REG_W-1:0] sow_max;
		logic [REG_W-1:0] mark_min;
		logic [REG_W-1:0] mark_max;
		logic [REG_W-1:0] one_min;
		logic [REG_W-1:0] space_max;
	} irpw_cfg_t;

	typedef struct packed {
		logic              new_word;
		logic [TIME_W-1:0] word;
		logic [PHASE_W-1:0] phase;
	} irpw_result_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [COUNT_W-1:0] mark_count;
	} irpw_status_t;

endpackage

// ===== rtl/irpw_cfg.sv =====
// Settings register file for the infrared pulse-width frame decoder.
// Depends on irpw_pkg for the register indexes, reset values and irpw_cfg_t.
module irpw_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [irpw_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [irpw_pkg::REG_W-1:0]        wr_data,
	output irpw_pkg::irpw_cfg_t               cfg
);

	irpw_pkg::irpw_cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sof_min   <= irpw_pkg::RST_SOF_MIN;
			regs_q.sof_max   <= irpw_pkg::RST_SOF_MAX;
			regs_q.sow_min   <= irpw_pkg::RST_SOW_MIN;
			regs_q.sow_max   <= irpw_pkg::RST_SOW_MAX;
			regs_q.mark_min  <= irpw_pkg::RST_MARK_MIN;
			regs_q.mark_max  <= irpw_pkg::RST_MARK_MAX;
			regs_q.one_min   <= irpw_pkg::RST_ONE_MIN;
			regs_q.space_max <= irpw_pkg::RST_SPACE_MAX;
		end else if (wr_en) begin
			unique case (wr_index)
				irpw_pkg::REG_SOF_MIN:   regs_q.sof_min   <= wr_data;
				irpw_pkg::REG_SOF_MAX:   regs_q.sof_max   <= wr_data;
				irpw_pkg::REG_SOW_MIN:   regs_q.sow_min   <= wr_data;
				irpw_pkg::REG_SOW_MAX:   regs_q.sow_max   <= wr_data;
				irpw_pkg::REG_MARK_MIN:  regs_q.mark_min  <= wr_data;
				irpw_pkg::REG_MARK_MAX:  regs_q.mark_max  <= wr_data;
				irpw_pkg::REG_ONE_MIN:   regs_q.one_min   <= wr_data;
				irpw_pkg::REG_SPACE_MAX: regs_q.space_max <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ===== rtl/irpw_core.sv =====
// Phase machine and frame state of the infrared pulse-width frame decoder.
// Depends on irpw_pkg; the result for an edge is combinational on the stored state.
module irpw_core #(
	parameter int unsigned SOR_MIN_TICKS = 125,
	parameter int unsigned SOR_MAX_TICKS = 375,
	parameter int unsigned BIT_MIN_TICKS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [irpw_pkg::TIME_W-1:0]    edge_time,
	input  logic                           pin_level,
	input  irpw_pkg::irpw_cfg_t            cfg,
	output irpw_pkg::irpw_result_t         result,
	output irpw_pkg::irpw_status_t         status
);

	localparam logic [irpw_pkg::TIME_W-1:0] SorMin =
		irpw_pkg::TIME_W'(SOR_MIN_TICKS);
	localparam logic [irpw_pkg::TIME_W-1:0] SorMax =
		irpw_pkg::TIME_W'(SOR_MAX_TICKS);
	localparam logic [irpw_pkg::TIME_W-1:0] BitMin =
		irpw_pkg::TIME_W'(BIT_MIN_TICKS);

	logic                           last_level_q;
	logic [irpw_pkg::TIME_W-1:0]    last_time_q;
	logic [irpw_pkg::PHASE_W-1:0]   phase_q;
	logic [irpw_pkg::TIME_W-1:0]    shift_q;
	logic [irpw_pkg::COUNT_W-1:0]   count_q;
	logic [irpw_pkg::TIME_W-1:0]    held_q;

	logic                           changed;
	logic [irpw_pkg::TIME_W-1:0]    raw_width;
	logic                           near_wrap;
	logic [irpw_pkg::TIME_W-1:0]    width;
	logic [irpw_pkg::TIME_W-1:0]    now_adj;
	logic [irpw_pkg::COUNT_W-1:0]   count_inc;

	logic [irpw_pkg::PHASE_W-1:0]   phase_d;
	logic [irpw_pkg::TIME_W-1:0]    shift_d;
	logic [irpw_pkg::COUNT_W-1:0]   count_d;
	logic [irpw_pkg::TIME_W-1:0]    held_d;
	logic                           new_d;

	function automatic logic in_win(input logic [irpw_pkg::TIME_W-1:0] w,
			input logic [irpw_pkg::TIME_W-1:0] lo,
			input logic [irpw_pkg::TIME_W-1:0] hi);
		return (w > lo) && (w < hi);
	endfunction

	assign changed   = pin_level != last_level_q;
	assign raw_width = edge_time - last_time_q;
	assign near_wrap = raw_width >= irpw_pkg::WRAP_LIMIT;
	assign width     = near_wrap ? raw_width + irpw_pkg::WRAP_FIX : raw_width;
	assign now_adj   = near_wrap ? edge_time + irpw_pkg::WRAP_FIX : edge_time;
	assign count_inc = count_q + irpw_pkg::COUNT_W'(1);

	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		count_d = count_q;
		held_d  = held_q;
		new_d   = 1'b0;
		if (changed) begin
			phase_d = irpw_pkg::PH_IDLE;
			if (pin_level) begin
				unique case (phase_q)
					irpw_pkg::PH_SOF: begin
						if (in_win(width, 32'(cfg.sof_min), 32'(cfg.sof_max))) begin
							phase_d = irpw_pkg::PH_SOW;
							shift_d = '0;
							count_d = '0;
						end
					end
					irpw_pkg::PH_MARK: begin
						if (in_win(width, 32'(cfg.mark_min), 32'(cfg.mark_max))) begin
							count_d = count_inc;
							if (count_inc < irpw_pkg::LAST_MARK) begin
								phase_d = irpw_pkg::PH_BIT;
							end else if (count_inc == irpw_pkg::LAST_MARK) begin
								held_d = shift_q;
								new_d  = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end else begin
				unique case (phase_q)
					irpw_pkg::PH_IDLE: phase_d = irpw_pkg::PH_SOF;
					irpw_pkg::PH_SOW: begin
						if (in_win(width, 32'(cfg.sow_min), 32'(cfg.sow_max))) begin
							phase_d = irpw_pkg::PH_MARK;
						end else if (in_win(width, SorMin, SorMax)) begin
							phase_d = irpw_pkg::PH_REP;
						end
					end
					irpw_pkg::PH_BIT: begin
						if (width >= BitMin && width < 32'(cfg.space_max)) begin
							// Bits arrive most significant first.
							shift_d = {shift_q[irpw_pkg::TIME_W-2:0],
								width > 32'(cfg.one_min)};
							phase_d = irpw_pkg::PH_MARK;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			last_time_q  <= '0;
			phase_q      <= irpw_pkg::PH_IDLE;
			shift_q      <= '0;
			count_q      <= '0;
			held_q       <= '0;
		end else if (step) begin
			if (changed) begin
				last_level_q <= pin_level;
				last_time_q  <= now_adj;
			end
			phase_q <= phase_d;
			shift_q <= shift_d;
			count_q <= count_d;
			held_q  <= held_d;
		end
	end

	assign result.new_word = new_d;
	assign result.word     = held_d;
	assign result.phase    = phase_d;

	assign status.phase      = phase_q;
	assign status.mark_count = count_q;

endmodule

// ===== rtl/ir_pulse_width_frame_decoder.sv =====
// Top level of the infrared pulse-width frame decoder: stream ports, edge register,
// result register. Depends on irpw_pkg, irpw_cfg and irpw_core.
//
// Channel  Direction  Handshake                Payload
// s_*      in         s_tvalid / s_tready      one pin edge: time stamp and level
// m_*      out        m_tvalid / m_tready      one result per edge
// cfg_*    in         cfg_valid / cfg_ready    register index and 16-bit value
//
// An edge waits in the edge register, where the phase machine evaluates it against
// the stored state, and its result is registered in the result register once that
// register frees up. Sustained rate is one edge per cycle while m_tready is high.
// Reset clears the frame state and loads the register defaults; settings writes are
// always taken. A stall on m_tready holds the result and the edge behind it, and
// backs up to s_tready in the same cycle.
module ir_pulse_width_frame_decoder #(
	parameter int unsigned SOR_MIN_TICKS = 125,
	parameter int unsigned SOR_MAX_TICKS = 375,
	parameter int unsigned BIT_MIN_TICKS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [31:0] edge_time, [32] pin_level, [39:33] zero
	input  logic [irpw_pkg::S_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] new_word, [32:1] word, [35:33] phase, [39:36] zero
	output logic [irpw_pkg::M_DATA_W-1:0]       m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [irpw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irpw_pkg::REG_W-1:0]          cfg_data
);

	irpw_pkg::irpw_cfg_t     cfg;
	irpw_pkg::irpw_result_t  result;
	irpw_pkg::irpw_status_t  status;

	logic                          valid_s1;
	logic [irpw_pkg::TIME_W-1:0]   time_s1;
	logic                          level_s1;
	logic                          advance;
	logic                          out_valid_q;
	irpw_pkg::irpw_result_t        out_q;

	assign cfg_ready = 1'b1;

	irpw_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register frees up when empty or being taken this cycle.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			time_s1  <= s_tdata[irpw_pkg::TIME_W-1:0];
			level_s1 <= s_tdata[irpw_pkg::TIME_W];
		end
	end

	irpw_core #(
		.SOR_MIN_TICKS (SOR_MIN_TICKS),
		.SOR_MAX_TICKS (SOR_MAX_TICKS),
		.BIT_MIN_TICKS (BIT_MIN_TICKS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.edge_time (time_s1),
		.pin_level (level_s1),
		.cfg       (cfg),
		.result    (result),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.phase, out_q.word, out_q.new_word};

`ifndef ASSERT_OFF
	// A completed frame always leaves the machine idle.
	a_word_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[35:33] == irpw_pkg::PH_IDLE)
		else $error("new_word reported outside the idle phase");

	// The mark count never runs past the frame length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.mark_count <= irpw_pkg::LAST_MARK)
		else $error("mark count beyond frame length");

	// Counting marks only happens between start-of-word and the end of the frame.
	a_count_phase: assert property (@(posedge clk) disable iff (!arst_n)
		status.mark_count != $past(status.mark_count) && status.mark_count != '0
		|-> $past(status.phase) == irpw_pkg::PH_MARK)
		else $error("mark count moved outside the mark phase");

	// A held edge stays in place while the result register is blocked.
	a_edge_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(time_s1) && $stable(level_s1))
		else $error("pending edge lost during stall");
`endif

endmodule
